[rtl/core/efrb_pkg.sv]
// ----------------------------------------------------------------------------
// efrb_pkg
// Shared types and constants of the escaped frame receive buffer.
// ----------------------------------------------------------------------------
package efrb_pkg;

  localparam int BYTE_W = 8;
  localparam int FILL_W = 9;
  localparam int LEN_W  = 10;
  localparam int CIDX_W = 2;

  // register indexes of the configuration port
  localparam logic [CIDX_W-1:0] CFG_START_FLAG = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_END_FLAG   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_ESCAPE     = 2'd2;

  localparam logic [BYTE_W-1:0] START_FLAG_RST = 8'd126;
  localparam logic [BYTE_W-1:0] END_FLAG_RST   = 8'd127;
  localparam logic [BYTE_W-1:0] ESCAPE_RST     = 8'd125;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_POP   = 2'd1,
    OP_QUERY = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  // controller to datapath
  typedef struct packed {
    logic    put;
    logic    pop_rd;
    logic    ring_clear;
    logic    scan_init;
    logic    scan_step;
    logic    fin;
    opcode_t fin_op;
    logic    fin_empty;
    logic    fin_eor;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ring_empty;
    logic scan_done;
  } dp_stat_t;

endpackage

[rtl/core/efrb_ctrl.sv]
// ----------------------------------------------------------------------------
// efrb_ctrl
// Operation sequencer: accepts a command, steps the scan, strobes the result.
// ----------------------------------------------------------------------------
module efrb_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_opcode,
  input  logic                   in_end_of_read,
  input  efrb_pkg::dp_stat_t     stat_i,
  output efrb_pkg::dp_cmd_t      cmd_o,
  output logic                   out_valid
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  efrb_pkg::opcode_t op_r;
  logic              empty_r;
  logic              eor_r;
  logic              out_valid_r;
  efrb_pkg::opcode_t op_in;

  assign op_in = efrb_pkg::opcode_t'(in_opcode);

  always_comb begin
    state_nxt       = state_r;
    cmd_o           = '0;
    cmd_o.fin_op    = op_r;
    cmd_o.fin_empty = empty_r;
    cmd_o.fin_eor   = eor_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_FIN;
          case (op_in)
            efrb_pkg::OP_PUT:   cmd_o.put = 1'b1;
            efrb_pkg::OP_POP:   cmd_o.pop_rd = !stat_i.ring_empty;
            efrb_pkg::OP_QUERY: begin
              cmd_o.scan_init = 1'b1;
              state_nxt       = S_SCAN;
            end
            efrb_pkg::OP_CLEAR: cmd_o.ring_clear = 1'b1;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          state_nxt = S_FIN;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= efrb_pkg::OP_PUT;
      empty_r     <= 1'b0;
      eor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_FIN);
      if (state_r == S_IDLE && start) begin
        op_r    <= op_in;
        empty_r <= stat_i.ring_empty;
        eor_r   <= in_end_of_read;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/core/efrb_dp.sv]
// ----------------------------------------------------------------------------
// efrb_dp
// Ring memory, head and tail pointers, escape tracking and frame scan.
// ----------------------------------------------------------------------------
module efrb_dp #(
  parameter int RING_DEPTH = 512
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  efrb_pkg::dp_cmd_t                    cmd_i,
  output efrb_pkg::dp_stat_t                   stat_o,
  input  logic [efrb_pkg::BYTE_W-1:0]          byte_in_i,
  input  logic                                 cfg_we_i,
  input  logic [efrb_pkg::CIDX_W-1:0]          cfg_index_i,
  input  logic [efrb_pkg::BYTE_W-1:0]          cfg_data_i,
  output logic [efrb_pkg::BYTE_W-1:0]          byte_out_o,
  output logic                                 byte_valid_o,
  output logic [efrb_pkg::FILL_W-1:0]          fill_level_o,
  output logic [efrb_pkg::LEN_W-1:0]           frame_length_o,
  output logic                                 status_o
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_POS = AW'(RING_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_F  = (AW+1)'(RING_DEPTH);
  localparam logic [AW+1:0] DEPTH_L  = (AW+2)'(RING_DEPTH);

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
    return (p == LAST_POS) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW:0] fill_of(input logic [AW-1:0] t, input logic [AW-1:0] h);
    logic [AW:0] tw;
    logic [AW:0] hw;
    tw = {1'b0, t};
    hw = {1'b0, h};
    return (t >= h) ? (tw - hw) : (DEPTH_F - (hw - tw));
  endfunction

  logic [efrb_pkg::BYTE_W-1:0] mem_r [RING_DEPTH];
  logic [efrb_pkg::BYTE_W-1:0] rd_data_r;
  logic                        rd_en;
  logic [AW-1:0]               rd_addr;

  logic [efrb_pkg::BYTE_W-1:0] start_flag_r, end_flag_r, escape_r;
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic          esc_r, esc_nxt;

  // scan state
  logic [AW-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [AW:0]   scan_left_r, scan_left_nxt;
  logic [AW-1:0] rd_pos_r, rd_pos_nxt;
  logic          rd_vld_r, rd_vld_nxt;
  logic          sc_esc_r, sc_esc_nxt;
  logic          s_found_r, s_found_nxt, e_found_r, e_found_nxt;
  logic [AW-1:0] s_pos_r, s_pos_nxt, e_pos_r, e_pos_nxt;

  logic [efrb_pkg::BYTE_W-1:0] byte_out_nxt;
  logic                        byte_valid_nxt;
  logic [AW+1:0]               span;
  logic                        is_pop;

  logic [efrb_pkg::BYTE_W-1:0] byte_out_r;
  logic                        byte_valid_r;
  logic [efrb_pkg::FILL_W-1:0] fill_level_r;
  logic [efrb_pkg::LEN_W-1:0]  frame_length_r;
  logic                        status_r;

  assign rd_en   = cmd_i.pop_rd || (cmd_i.scan_step && scan_left_r != '0);
  assign rd_addr = cmd_i.pop_rd ? head_r : scan_ptr_r;

  always_ff @(posedge clk) begin
    if (cmd_i.put) begin
      mem_r[tail_r] <= byte_in_i;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign is_pop = (cmd_i.fin_op == efrb_pkg::OP_POP) && !cmd_i.fin_empty;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    esc_nxt        = esc_r;
    scan_ptr_nxt   = scan_ptr_r;
    scan_left_nxt  = scan_left_r;
    rd_pos_nxt     = rd_pos_r;
    rd_vld_nxt     = rd_vld_r;
    sc_esc_nxt     = sc_esc_r;
    s_found_nxt    = s_found_r;
    e_found_nxt    = e_found_r;
    s_pos_nxt      = s_pos_r;
    e_pos_nxt      = e_pos_r;
    byte_out_nxt   = '0;
    byte_valid_nxt = 1'b0;

    if (cmd_i.put) begin
      tail_nxt = next_pos(tail_r);
    end
    if (cmd_i.ring_clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      esc_nxt  = 1'b0;
    end
    if (cmd_i.scan_init) begin
      scan_ptr_nxt  = head_r;
      scan_left_nxt = fill_of(tail_r, head_r);
      rd_vld_nxt    = 1'b0;
      sc_esc_nxt    = 1'b0;
      s_found_nxt   = 1'b0;
      e_found_nxt   = 1'b0;
    end
    if (cmd_i.scan_step) begin
      // issue the next read while checking the byte read last cycle
      rd_vld_nxt = (scan_left_r != '0);
      rd_pos_nxt = scan_ptr_r;
      if (scan_left_r != '0) begin
        scan_ptr_nxt  = next_pos(scan_ptr_r);
        scan_left_nxt = scan_left_r - 1'b1;
      end
      if (rd_vld_r) begin
        if (rd_data_r == escape_r && !sc_esc_r) begin
          sc_esc_nxt = 1'b1;
        end else begin
          if (!sc_esc_r) begin
            if (rd_data_r == start_flag_r && !s_found_r) begin
              s_found_nxt = 1'b1;
              s_pos_nxt   = rd_pos_r;
            end
            if (rd_data_r == end_flag_r && !e_found_r) begin
              e_found_nxt = 1'b1;
              e_pos_nxt   = rd_pos_r;
            end
          end
          sc_esc_nxt = 1'b0;
        end
      end
    end
    if (cmd_i.fin && is_pop) begin
      head_nxt = next_pos(head_r);
      if (rd_data_r == escape_r && !esc_r) begin
        esc_nxt = 1'b1;
      end else begin
        byte_out_nxt   = rd_data_r;
        byte_valid_nxt = 1'b1;
        esc_nxt        = 1'b0;
      end
      if (cmd_i.fin_eor) begin
        esc_nxt = 1'b0;
      end
    end
  end

  // inclusive span from start flag to end flag, wrapped
  always_comb begin
    if (!s_found_r || !e_found_r || s_pos_r == e_pos_r) begin
      span = '0;
    end else if (s_pos_r < e_pos_r) begin
      span = (AW+2)'(e_pos_r) - (AW+2)'(s_pos_r) + 1'b1;
    end else begin
      span = DEPTH_L - ((AW+2)'(s_pos_r) - (AW+2)'(e_pos_r)) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_flag_r <= efrb_pkg::START_FLAG_RST;
      end_flag_r   <= efrb_pkg::END_FLAG_RST;
      escape_r     <= efrb_pkg::ESCAPE_RST;
      head_r       <= '0;
      tail_r       <= '0;
      esc_r        <= 1'b0;
      scan_ptr_r   <= '0;
      scan_left_r  <= '0;
      rd_pos_r     <= '0;
      rd_vld_r     <= 1'b0;
      sc_esc_r     <= 1'b0;
      s_found_r    <= 1'b0;
      e_found_r    <= 1'b0;
      s_pos_r      <= '0;
      e_pos_r      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          efrb_pkg::CFG_START_FLAG: start_flag_r <= cfg_data_i;
          efrb_pkg::CFG_END_FLAG:   end_flag_r   <= cfg_data_i;
          efrb_pkg::CFG_ESCAPE:     escape_r     <= cfg_data_i;
          default: ;
        endcase
      end
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      esc_r       <= esc_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      scan_left_r <= scan_left_nxt;
      rd_pos_r    <= rd_pos_nxt;
      rd_vld_r    <= rd_vld_nxt;
      sc_esc_r    <= sc_esc_nxt;
      s_found_r   <= s_found_nxt;
      e_found_r   <= e_found_nxt;
      s_pos_r     <= s_pos_nxt;
      e_pos_r     <= e_pos_nxt;
    end
  end

  // result word, loaded once per operation
  always_ff @(posedge clk) begin
    if (cmd_i.fin) begin
      byte_out_r     <= byte_out_nxt;
      byte_valid_r   <= byte_valid_nxt;
      fill_level_r   <= efrb_pkg::FILL_W'(fill_of(tail_nxt, head_nxt));
      frame_length_r <= (cmd_i.fin_op == efrb_pkg::OP_QUERY) ?
                        efrb_pkg::LEN_W'(span) : '0;
      status_r       <= (cmd_i.fin_op == efrb_pkg::OP_POP) && cmd_i.fin_empty;
    end
  end

  assign byte_out_o     = byte_out_r;
  assign byte_valid_o   = byte_valid_r;
  assign fill_level_o   = fill_level_r;
  assign frame_length_o = frame_length_r;
  assign status_o       = status_r;

  assign stat_o.ring_empty = (head_r == tail_r);
  assign stat_o.scan_done  = (s_found_r && e_found_r) || (!rd_vld_r && scan_left_r == '0);

`ifndef SYNTH
  a_pop_read_issued: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.fin && is_pop |-> $past(cmd_i.pop_rd))
    else $error("pop finished without a ring read");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.ring_clear |=> head_r == '0 && tail_r == '0 && !esc_r)
    else $error("ring clear left pointers or escape set");

  a_no_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.fin && cmd_i.fin_op == efrb_pkg::OP_QUERY && !(s_found_r && e_found_r)
    |=> frame_length_o == '0)
    else $error("frame length reported with a flag missing");
`endif

endmodule

[rtl/core/escaped_frame_receive_buffer.sv]
// ----------------------------------------------------------------------------
// escaped_frame_receive_buffer
// Byte-stuffed receive ring with pop deframing and next-frame size query.
// ----------------------------------------------------------------------------
// put, pop and ring reset: start leads to the finish state, the result strobe is registered
//   from it, and the next start is taken in the strobe cycle.
// size query: the scan reads one ring byte per cycle through the single memory
//   read port and stops once both flags are seen or the ring bytes run out.
// reset (synchronous, rst_n low): pointers, escape state and flags to defaults;
//   ring contents are kept and need no clearing pass. results cannot be stalled.
module escaped_frame_receive_buffer #(
  parameter int RING_DEPTH = 512
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic [efrb_pkg::BYTE_W-1:0]       in_byte_in,
  input  logic                              in_end_of_read,
  output logic                              out_valid,
  output logic [efrb_pkg::BYTE_W-1:0]       out_byte_out,
  output logic                              out_byte_valid,
  output logic [efrb_pkg::FILL_W-1:0]       out_fill_level,
  output logic [efrb_pkg::LEN_W-1:0]        out_frame_length,
  output logic                              out_status,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [efrb_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [efrb_pkg::BYTE_W-1:0]       cfg_data
);

  efrb_pkg::dp_cmd_t  cmd;
  efrb_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  efrb_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_end_of_read (in_end_of_read),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .out_valid      (out_valid)
  );

  efrb_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .byte_in_i      (in_byte_in),
    .cfg_we_i       (cfg_valid && cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .byte_out_o     (out_byte_out),
    .byte_valid_o   (out_byte_valid),
    .fill_level_o   (out_fill_level),
    .frame_length_o (out_frame_length),
    .status_o       (out_status)
  );

endmodule
